// ===== sv/rbci_pkg.sv =====
// ----------------------------------------------------------------------------
// rbci_pkg
// Shared types and constants for the clock chip command interface.
// ----------------------------------------------------------------------------
package rbci_pkg;

   localparam int BRAM_DEPTH = 256;

   typedef enum logic [1:0] {
      OP_WRITE_DATA    = 2'd0,
      OP_WRITE_CONTROL = 2'd1,
      OP_READ_DATA     = 2'd2,
      OP_READ_CONTROL  = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CTRL_IDLE = 1'b0,
      CTRL_READ = 1'b1
   } ctrl_state_type;

   localparam logic [3:0] STEP_COMMAND = 4'd0;
   localparam logic [3:0] STEP_ADDRESS = 4'd1;
   localparam logic [3:0] STEP_ACCESS  = 4'd2;

   localparam logic [7:0] BRAM_CMD_MASK   = 8'h78;
   localparam logic [7:0] BRAM_CMD_MATCH  = 8'h38;
   localparam logic [7:0] CLOCK_CMD_MASK  = 8'h73;
   localparam logic [7:0] CLOCK_CMD_MATCH = 8'h01;
   localparam logic [7:0] BRAM_PHASE      = 8'h41;
   localparam logic [7:0] CLOCK_PHASE     = 8'h02;

   typedef struct packed {
      logic       re;
      logic       we;
      logic [7:0] addr;
      logic [7:0] wdata;
   } bram_req_type;

endpackage

// ===== sv/rbci_bram.sv =====
// ----------------------------------------------------------------------------
// rbci_bram
// Battery RAM: synchronous memory with registered read data, with per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rbci_bram #(
   parameter int BRAM_DEPTH = rbci_pkg::BRAM_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbci_pkg::bram_req_type req,
   output logic [7:0]            rdata
);
   import rbci_pkg::*;

   localparam int ADDR_W = $clog2(BRAM_DEPTH);

   logic [7:0]            bram_ff [BRAM_DEPTH];
   logic [BRAM_DEPTH-1:0] valid_ff;
   logic [7:0]            rdata_ff;
   logic                  rvalid_ff;
   logic [ADDR_W-1:0]     addr;

   assign addr = req.addr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (req.we) begin
         bram_ff[addr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= bram_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (req.we) begin
            valid_ff[addr] <= 1'b1;
         end
         if (req.re) begin
            rvalid_ff <= valid_ff[addr];
         end
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : 8'h00;

endmodule

// ===== sv/rbci_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbci_ctrl
// Data and control registers, command sequencer and clock latch. Issues
// battery RAM accesses and waits in a read state for the RAM read data.
// ----------------------------------------------------------------------------
module rbci_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             opcode,
   input  logic [7:0]             write_value,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   input  logic [7:0]             bram_rdata,
   output rbci_pkg::bram_req_type bram_req,
   output logic [7:0]             read_value,
   output logic                   busy
);
   import rbci_pkg::*;

   ctrl_state_type state_ff, state_in;

   logic [31:0] clock_value_ff;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  control_ff, control_in;
   logic [3:0]  border_ff, border_in;
   logic [7:0]  phase_ff, phase_in;
   logic [7:0]  target_ff, target_in;
   logic [31:0] latched_ff, latched_in;
   logic [7:0]  d;
   logic [31:0] time_word;
   logic        read_start;

   always_comb begin
      data_in    = data_ff;
      control_in = control_ff;
      border_in  = border_ff;
      phase_in   = phase_ff;
      target_in  = target_ff;
      latched_in = latched_ff;
      read_value = 8'h00;
      bram_req   = '0;
      read_start = 1'b0;
      d          = write_value[5] ? data_ff : 8'h00;
      time_word  = (target_ff == 8'h00) ? clock_value_ff : latched_ff;

      if (state_ff == CTRL_READ) begin
         data_in = bram_rdata;
      end else if (accept) begin
         case (opcode_type'(opcode))
            OP_WRITE_DATA: begin
               data_in = write_value;
            end
            OP_WRITE_CONTROL: begin
               border_in  = write_value[3:0];
               control_in = {1'b0, write_value[6:4]};
               data_in    = d;
               case (phase_ff[3:0])
                  STEP_COMMAND: begin
                     if ((d & BRAM_CMD_MASK) == BRAM_CMD_MATCH) begin
                        phase_in  = {d[7], 7'h00} | BRAM_PHASE;
                        target_in = {d[2:0], 5'b00000};
                     end else if ((d & CLOCK_CMD_MASK) == CLOCK_CMD_MATCH) begin
                        phase_in  = {d[7], 7'h00} | CLOCK_PHASE;
                        target_in = {6'b000000, d[3:2]};
                     end
                  end
                  STEP_ADDRESS: begin
                     target_in = target_ff | {3'b000, d[6:2]};
                     phase_in  = phase_ff + 8'd1;
                  end
                  STEP_ACCESS: begin
                     if (phase_ff[6]) begin
                        bram_req.addr  = target_ff;
                        bram_req.wdata = d;
                        if (phase_ff[7]) begin
                           bram_req.re = 1'b1;
                           read_start  = 1'b1;
                        end else begin
                           bram_req.we = 1'b1;
                        end
                     end else if (phase_ff[7]) begin
                        if (target_ff == 8'h00) begin
                           latched_in = clock_value_ff;
                        end
                        case (target_ff[1:0])
                           2'd0:    data_in = time_word[7:0];
                           2'd1:    data_in = time_word[15:8];
                           2'd2:    data_in = time_word[23:16];
                           default: data_in = time_word[31:24];
                        endcase
                     end
                     phase_in = 8'h00;
                  end
                  default: begin
                     phase_in = 8'h00;
                  end
               endcase
            end
            OP_READ_DATA: begin
               read_value = data_ff;
            end
            default: begin
               read_value = {control_ff, border_ff};
            end
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         CTRL_IDLE: state_in = read_start ? CTRL_READ : CTRL_IDLE;
         CTRL_READ: state_in = CTRL_IDLE;
         default:   state_in = CTRL_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         CTRL_READ: busy = 1'b1;
         default:   busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CTRL_IDLE;
         clock_value_ff <= '0;
         data_ff        <= '0;
         control_ff     <= '0;
         border_ff      <= '0;
         phase_ff       <= '0;
         target_ff      <= '0;
         latched_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         data_ff    <= data_in;
         control_ff <= control_in;
         border_ff  <= border_in;
         phase_ff   <= phase_in;
         target_ff  <= target_in;
         latched_ff <= latched_in;
         if (csr_write_enable) begin
            clock_value_ff <= csr_write_data;
         end
      end
   end

endmodule

// ===== sv/rtc_bram_command_interface_top.sv =====
// ----------------------------------------------------------------------------
// rtc_bram_command_interface_top
// Clock chip command interface with battery RAM behind a data and a
// control register.
//
//   port group   dir  handshake            payload
//   req_         in   req_valid/req_ready  req_opcode, req_write_value
//   rsp_         out  rsp_valid/rsp_ready  rsp_read_value
//   csr_         in   csr_write_enable     csr_write_data (clock value)
//
// One item per cycle unless a response is held untaken or a RAM read waits; a
// control write that issues a battery RAM read holds off the next item until the RAM data is loaded.
// A result not taken holds the input; one taken in the same cycle frees it.
// Reset is synchronous; valid bits make the RAM read as zero at once.
// ----------------------------------------------------------------------------
module rtc_bram_command_interface_top #(
   parameter int BRAM_DEPTH = rbci_pkg::BRAM_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import rbci_pkg::*;

   bram_req_type bram_req;
   logic [7:0]   bram_rdata;
   logic [7:0]   result;
   logic         busy;
   logic         accept;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_value_ff;

   assign req_ready = !busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   rbci_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .opcode           (req_opcode),
      .write_value      (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .bram_rdata       (bram_rdata),
      .bram_req         (bram_req),
      .read_value       (result),
      .busy             (busy)
   );

   rbci_bram #(
      .BRAM_DEPTH (BRAM_DEPTH)
   ) u_bram (
      .clock (clock),
      .reset (reset),
      .req   (bram_req),
      .rdata (bram_rdata)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

   a_read_wait_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("read wait lasted more than one cycle");

   a_read_enters_wait: assert property (@(posedge clock) disable iff (reset)
      bram_req.re |=> busy)
      else $error("RAM read issued without waiting for data");

   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      bram_req.we |-> (accept && !bram_req.re))
      else $error("RAM write outside an accepted item");

endmodule
